[hw/rtl/hfls_pkg.sv]
// ----------------------------------------------------------------------------
// hfls_pkg: shared types and arithmetic for the HMM forward recursion block
// Codes, state machine types, saturating Q16.16 sums and the log-add helper.
// ----------------------------------------------------------------------------
package hfls_pkg;

   localparam int MAX_STATES_DEF = 64;
   localparam int SCORE_W        = 32;

   localparam logic [6:0]         STATES_RESET = 7'd64;
   localparam logic signed [31:0] NEG_INF      = 32'sh8000_0000;
   localparam logic signed [31:0] POS_MAX      = 32'sh7FFF_FFFF;

   // request codes
   localparam logic [2:0] REQ_SET_TRANS = 3'd0;
   localparam logic [2:0] REQ_SET_INIT  = 3'd1;
   localparam logic [2:0] REQ_SET_END   = 3'd2;
   localparam logic [2:0] REQ_EMIT      = 3'd3;
   localparam logic [2:0] REQ_FINISH    = 3'd4;

   // position marks
   localparam logic [1:0] MARK_SAME  = 2'd0;
   localparam logic [1:0] MARK_FIRST = 2'd1;
   localparam logic [1:0] MARK_NEXT  = 2'd2;

   // result kinds
   localparam logic KIND_STATE = 1'b0;
   localparam logic KIND_TOTAL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_FLUSH,
      ST_RESP
   } fsm_type;

   typedef enum logic [1:0] {
      OP_EMIT_FIRST,
      OP_EMIT_LOOP,
      OP_FINISH
   } op_type;

   // log(1+exp(-k/2)) in Q16.16
   function automatic logic [15:0] corr_lookup(input logic [3:0] k);
      logic [15:0] v;
      case (k)
         4'd0:    v = 16'd45426;
         4'd1:    v = 16'd31069;
         4'd2:    v = 16'd20530;
         4'd3:    v = 16'd13200;
         4'd4:    v = 16'd8318;
         4'd5:    v = 16'd5170;
         4'd6:    v = 16'd3184;
         4'd7:    v = 16'd1950;
         4'd8:    v = 16'd1189;
         4'd9:    v = 16'd724;
         4'd10:   v = 16'd440;
         4'd11:   v = 16'd267;
         4'd12:   v = 16'd162;
         4'd13:   v = 16'd98;
         4'd14:   v = 16'd60;
         4'd15:   v = 16'd36;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] clamp_sum(input logic signed [33:0] s);
      logic signed [31:0] r;
      if (s <= -34'sd2147483648) begin
         r = NEG_INF;
      end else if (s > 34'sd2147483647) begin
         r = POS_MAX;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] add3(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic signed [31:0] c);
      logic signed [33:0] s;
      s = 34'(a) + 34'(b) + 34'(c);
      if (a == NEG_INF || b == NEG_INF || c == NEG_INF) begin
         return NEG_INF;
      end
      return clamp_sum(s);
   endfunction

   function automatic logic signed [31:0] log_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] diff;
      logic signed [31:0] m;
      logic        [32:0] d;
      logic signed [33:0] s;
      diff = 33'(a) - 33'(b);
      m    = diff[32] ? b : a;
      d    = diff[32] ? 33'(-diff) : 33'(diff);
      s    = 34'(m) + 34'(signed'({1'b0, corr_lookup(d[18:15])}));
      if (a == NEG_INF) begin
         return b;
      end
      if (b == NEG_INF) begin
         return a;
      end
      if (d >= 33'd524288) begin
         return m;
      end
      return clamp_sum(s);
   endfunction

endpackage

[hw/rtl/hmm_forward_log_space.sv]
// ----------------------------------------------------------------------------
// hmm_forward_log_space: log-space HMM forward recursion engine
// Table loader plus a sequencer that walks states through one log-add unit.
// ----------------------------------------------------------------------------
// Usage: load transition, initial and end scores with set requests; each
// leaves busy low. An emission or finish request raises busy and walks the n
// participating states (n = states_in_use, capped at MAX_STATES) through a
// single read / add / log-add pipeline, one state per cycle. Only the
// emitting state is read at the first position of a sequence, and nothing is
// walked when the emitting state does not participate or n is zero. The last
// busy cycle carries the answer. The answer appears on the rsp_ ports for
// exactly one cycle under rsp_strobe; the receiver cannot stall it, so sample
// it on that cycle. Write states_in_use only while busy is low.
// No clearing pass follows reset: column entries carry valid bits.
// ----------------------------------------------------------------------------
module hmm_forward_log_space
   import hfls_pkg::*;
#(
   parameter int MAX_STATES = MAX_STATES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_type,
   input  logic [5:0]         req_from_state,
   input  logic [5:0]         req_to_state,
   input  logic signed [31:0] req_score,
   input  logic [1:0]         req_position_mark,
   output logic               rsp_strobe,
   output logic               rsp_result_kind,
   output logic [5:0]         rsp_state_index,
   output logic signed [31:0] rsp_log_score,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_states_in_use
);

   localparam int SW        = $clog2(MAX_STATES);
   localparam int CW        = $clog2(MAX_STATES + 1);
   localparam int TR_DEPTH  = MAX_STATES * MAX_STATES;
   localparam int AW        = $clog2(TR_DEPTH);
   localparam int COL_DEPTH = 2 * (2 ** SW);

   // storage
   logic signed [31:0] trans_mem [TR_DEPTH];
   logic signed [31:0] init_mem  [MAX_STATES];
   logic signed [31:0] end_mem   [MAX_STATES];
   logic signed [31:0] col_mem   [COL_DEPTH];
   logic               col_vld_ff [COL_DEPTH];

   // control
   fsm_type            state_ff, state_in;
   op_type             op_ff;
   logic [6:0]         states_ff;
   logic               at_first_ff;
   logic               cur_bank_ff;
   logic [SW-1:0]      p_ff;
   logic [SW-1:0]      last_ff;
   logic [SW-1:0]      to_ff;
   logic [5:0]         to_raw_ff;
   logic signed [31:0] score_ff;
   logic               wr_col_ff;

   // pipeline
   logic               rd_v_ff, term_v_ff;
   logic signed [31:0] col_rd_ff, trans_rd_ff, init_rd_ff, end_rd_ff;
   logic               col_vld_rd_ff;
   logic signed [31:0] term_ff, acc_ff;

   // decode
   logic               accept, issue_en, issue_last, skip_loop;
   logic [8:0]         to9, from9, n9;
   logic [CW-1:0]      n_act;
   logic [SW-1:0]      to_idx, from_idx;
   logic               to_ok, from_ok, to_active;
   logic               first_mode;
   logic               bank_sel;
   logic [SW:0]        col_addr;
   logic [AW-1:0]      tr_addr;
   logic signed [31:0] op_a, op_b, op_c, col_val;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign to9      = {3'b000, req_to_state};
   assign from9    = {3'b000, req_from_state};
   assign to_idx   = to9[SW-1:0];
   assign from_idx = from9[SW-1:0];
   assign to_ok    = 32'(to9) < MAX_STATES;
   assign from_ok  = 32'(from9) < MAX_STATES;

   // cap the register at the table size
   assign n9        = (32'({2'b00, states_ff}) > MAX_STATES) ? 9'(MAX_STATES)
                                                              : {2'b00, states_ff};
   assign n_act     = n9[CW-1:0];
   assign to_active = to9 < n9;

   // mark one restarts the sequence; mark two steps to the next position
   assign first_mode = (req_position_mark == MARK_FIRST) ||
                       ((req_position_mark != MARK_NEXT) && at_first_ff);
   assign skip_loop  = (req_type == REQ_EMIT) ? !to_active : (n9 == 9'd0);

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_EMIT || req_type == REQ_FINISH)) begin
               state_in = skip_loop ? ST_RESP : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (issue_last) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!rd_v_ff && !term_v_ff) state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy       = 1'b1;
      issue_en   = 1'b0;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE:  busy       = 1'b0;
         ST_ISSUE: issue_en   = 1'b1;
         ST_FLUSH: busy       = 1'b1;
         ST_RESP:  rsp_strobe = 1'b1;
         default:  busy       = 1'b1;
      endcase
   end

   assign issue_last = (p_ff == last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         states_ff   <= STATES_RESET;
         at_first_ff <= 1'b1;
         cur_bank_ff <= 1'b0;
         rd_v_ff     <= 1'b0;
         term_v_ff   <= 1'b0;
         wr_col_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_v_ff   <= issue_en;
         term_v_ff <= rd_v_ff;
         if (csr_valid && csr_ready) states_ff <= csr_states_in_use;
         if (accept && req_type == REQ_EMIT) begin
            wr_col_ff <= to_active;
            if (req_position_mark == MARK_FIRST) begin
               at_first_ff <= 1'b1;
            end else if (req_position_mark == MARK_NEXT) begin
               at_first_ff <= 1'b0;
               cur_bank_ff <= ~cur_bank_ff;
            end
         end else if (accept) begin
            wr_col_ff <= 1'b0;
         end
      end
   end

   // column valid bits: drop on restart, drop the new current bank on a step
   always_ff @(posedge clock) begin
      for (int i = 0; i < COL_DEPTH; i++) begin
         if (reset) begin
            col_vld_ff[i] <= 1'b0;
         end else if (accept && req_type == REQ_EMIT &&
                      req_position_mark == MARK_FIRST) begin
            col_vld_ff[i] <= 1'b0;
         end else if (accept && req_type == REQ_EMIT &&
                      req_position_mark == MARK_NEXT &&
                      ((i / (2 ** SW)) != 32'(cur_bank_ff))) begin
            col_vld_ff[i] <= 1'b0;
         end else if (state_ff == ST_RESP && wr_col_ff &&
                      i == 32'({cur_bank_ff, to_ff})) begin
            col_vld_ff[i] <= 1'b1;
         end
      end
   end

   // item registers
   always_ff @(posedge clock) begin
      if (accept) begin
         to_ff     <= to_idx;
         to_raw_ff <= req_to_state;
         score_ff  <= req_score;
         p_ff      <= '0;
         acc_ff    <= NEG_INF;
         if (req_type == REQ_FINISH) begin
            op_ff   <= OP_FINISH;
            last_ff <= SW'(n_act - CW'(1));
         end else if (first_mode) begin
            op_ff   <= OP_EMIT_FIRST;
            last_ff <= '0;
         end else begin
            op_ff   <= OP_EMIT_LOOP;
            last_ff <= SW'(n_act - CW'(1));
         end
      end else begin
         if (issue_en) p_ff <= p_ff + SW'(1);
         if (term_v_ff) acc_ff <= log_add(acc_ff, term_ff);
      end
   end

   // ---------------------------------------------------------------------
   // table writes and pipeline reads
   // ---------------------------------------------------------------------
   assign tr_addr = AW'(32'(p_ff) * MAX_STATES) + AW'(to_ff);

   always_ff @(posedge clock) begin
      if (accept && req_type == REQ_SET_TRANS && to_ok && from_ok) begin
         trans_mem[AW'(32'(from_idx) * MAX_STATES) + AW'(to_idx)] <= req_score;
      end
      if (issue_en) trans_rd_ff <= trans_mem[tr_addr];
   end

   always_ff @(posedge clock) begin
      if (accept && req_type == REQ_SET_INIT && to_ok) init_mem[to_idx] <= req_score;
      if (issue_en) init_rd_ff <= init_mem[to_ff];
   end

   always_ff @(posedge clock) begin
      if (accept && req_type == REQ_SET_END && from_ok) end_mem[from_idx] <= req_score;
      if (issue_en) end_rd_ff <= end_mem[p_ff];
   end

   // previous bank feeds the recursion, current bank feeds the finish sum
   assign bank_sel = (op_ff == OP_FINISH) ? cur_bank_ff : ~cur_bank_ff;
   assign col_addr = {bank_sel, p_ff};

   always_ff @(posedge clock) begin
      if (state_ff == ST_RESP && wr_col_ff) col_mem[{cur_bank_ff, to_ff}] <= acc_ff;
      if (issue_en) begin
         col_rd_ff     <= col_mem[col_addr];
         col_vld_rd_ff <= col_vld_ff[col_addr];
      end
   end

   // ---------------------------------------------------------------------
   // three-operand sum ahead of the log-add unit
   // ---------------------------------------------------------------------
   assign col_val = col_vld_rd_ff ? col_rd_ff : NEG_INF;

   always_comb begin
      case (op_ff)
         OP_EMIT_FIRST: begin
            op_a = init_rd_ff;
            op_b = score_ff;
            op_c = '0;
         end
         OP_EMIT_LOOP: begin
            op_a = col_val;
            op_b = score_ff;
            op_c = trans_rd_ff;
         end
         OP_FINISH: begin
            op_a = col_val;
            op_b = end_rd_ff;
            op_c = '0;
         end
         default: begin
            op_a = NEG_INF;
            op_b = '0;
            op_c = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_v_ff) term_ff <= add3(op_a, op_b, op_c);
   end

   // result ports hold the finished accumulator during the strobe cycle
   assign rsp_result_kind = (op_ff == OP_FINISH) ? KIND_TOTAL : KIND_STATE;
   assign rsp_state_index = (op_ff == OP_FINISH) ? 6'd0 : to_raw_ff;
   assign rsp_log_score   = acc_ff;

endmodule

[hw/rtl/hfls_checker.sv]
// ----------------------------------------------------------------------------
// hfls_checker: port-level checks for the HMM forward recursion block
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module hfls_checker
   import hfls_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [2:0] req_type,
   input logic       rsp_strobe,
   input logic       rsp_result_kind,
   input logic [5:0] rsp_state_index
);

   // a result frees the block on the next cycle
   a_strobe_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy && !rsp_strobe)
      else $error("block still busy after a result");

   // a scoring transfer always occupies the block
   a_score_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == REQ_EMIT || req_type == REQ_FINISH)) |=> busy)
      else $error("scoring request did not raise busy");

   // table writes finish in the accept cycle and produce nothing
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == REQ_SET_TRANS || req_type == REQ_SET_INIT ||
                          req_type == REQ_SET_END)) |=> !busy && !rsp_strobe)
      else $error("table write produced activity");

   // a strobe only ends a busy period
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result without a scoring request");

   // totals report state zero
   a_total_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_result_kind == KIND_TOTAL) |-> rsp_state_index == 6'd0)
      else $error("total result with nonzero state index");

endmodule

bind hmm_forward_log_space hfls_checker u_hfls_checker (.*);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the log-space HMM forward recursion block
// Loads the score tables, drives directed and random emission sequences with
// random gaps, and checks every strobed result against a local predictor.
// ----------------------------------------------------------------------------
module tb
   import hfls_pkg::*;
();

   localparam logic [1:0] MARK_SPARE     = 2'd3;  // unused mark, same as MARK_SAME
   localparam logic [2:0] REQ_SPARE_LO   = 3'd5;  // first of the undefined codes
   localparam int         DRAIN_CYCLES   = 100;   // covers the longest busy period with margin
   localparam int         RANDOM_ITEMS   = 1200;

   typedef struct {
      logic               kind;
      logic [5:0]         idx;
      logic signed [31:0] score;
   } fwd_result_type;

   // log(1+exp(-k/2)) in Q16.16, steps of 0.5
   localparam int CORR[16] = '{45426, 31069, 20530, 13200, 8318, 5170, 3184, 1950,
                               1189, 724, 440, 267, 162, 98, 60, 36};

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_type;
   logic [5:0]         req_from_state;
   logic [5:0]         req_to_state;
   logic signed [31:0] req_score;
   logic [1:0]         req_position_mark;
   logic               rsp_strobe;
   logic               rsp_result_kind;
   logic [5:0]         rsp_state_index;
   logic signed [31:0] rsp_log_score;
   logic               csr_valid;
   logic               csr_ready;
   logic [6:0]         csr_states_in_use;

   // predictor state
   logic signed [31:0] trans_tbl [MAX_STATES_DEF*MAX_STATES_DEF];
   logic signed [31:0] init_tbl  [MAX_STATES_DEF];
   logic signed [31:0] end_tbl   [MAX_STATES_DEF];
   logic signed [31:0] prev_col  [MAX_STATES_DEF];
   logic signed [31:0] cur_col   [MAX_STATES_DEF];
   logic               first_pos;
   logic [6:0]         states_cfg;

   fwd_result_type pending_fwd[$];
   int             mismatch_count;
   bit             gaps_on;

   hmm_forward_log_space dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_from_state    (req_from_state),
      .req_to_state      (req_to_state),
      .req_score         (req_score),
      .req_position_mark (req_position_mark),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_state_index   (rsp_state_index),
      .rsp_log_score     (rsp_log_score),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_states_in_use (csr_states_in_use)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Fixed-point arithmetic of the predictor
   // ---------------------------------------------------------------------

   // saturate a wide sum: at or below the minimum is minus infinity
   function automatic logic signed [31:0] sat_q16(input longint s);
      if (s <= -64'sd2147483648) return NEG_INF;
      if (s > 64'sd2147483647) return POS_MAX;
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] sum_scores(input logic signed [31:0] a,
                                                     input logic signed [31:0] b,
                                                     input logic signed [31:0] c);
      if (a == NEG_INF || b == NEG_INF || c == NEG_INF) return NEG_INF;
      return sat_q16(longint'(a) + longint'(b) + longint'(c));
   endfunction

   // max plus table correction, minus infinity is the identity
   function automatic logic signed [31:0] log_sum(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [31:0] hi;
      longint             gap;
      if (a == NEG_INF) return b;
      if (b == NEG_INF) return a;
      hi  = (a > b) ? a : b;
      gap = (a > b) ? longint'(a) - longint'(b) : longint'(b) - longint'(a);
      if (gap >= 524288) return hi;
      return sat_q16(longint'(hi) + CORR[gap >> 15]);
   endfunction

   function automatic int active_states();
      return (states_cfg > MAX_STATES_DEF) ? MAX_STATES_DEF : int'(states_cfg);
   endfunction

   // Advance the predictor by one accepted request, queue any result.
   task automatic predict_transfer(input logic [2:0] kind, input logic [5:0] src,
                                   input logic [5:0] dst, input logic signed [31:0] sc,
                                   input logic [1:0] mark);
      fwd_result_type     r;
      logic signed [31:0] acc;
      int                 n;
      n   = active_states();
      acc = NEG_INF;
      case (kind)
         REQ_SET_TRANS: trans_tbl[src*MAX_STATES_DEF + dst] = sc;
         REQ_SET_INIT:  init_tbl[dst] = sc;
         REQ_SET_END:   end_tbl[src] = sc;
         REQ_EMIT: begin
            if (mark == MARK_FIRST) begin
               foreach (prev_col[i]) prev_col[i] = NEG_INF;
               foreach (cur_col[i]) cur_col[i] = NEG_INF;
               first_pos = 1'b1;
            end else if (mark == MARK_NEXT) begin
               foreach (cur_col[i]) begin
                  prev_col[i] = cur_col[i];
                  cur_col[i]  = NEG_INF;
               end
               first_pos = 1'b0;
            end
            if (dst < n) begin
               if (first_pos) begin
                  acc = sum_scores(init_tbl[dst], sc, 0);
               end else begin
                  for (int p = 0; p < n; p++) begin
                     if (prev_col[p] != NEG_INF)
                        acc = log_sum(acc, sum_scores(prev_col[p], sc,
                                                      trans_tbl[p*MAX_STATES_DEF + dst]));
                  end
               end
               cur_col[dst] = acc;
            end
            r.kind = KIND_STATE; r.idx = dst; r.score = acc;
            pending_fwd.push_back(r);
         end
         REQ_FINISH: begin
            for (int p = 0; p < n; p++) begin
               if (cur_col[p] != NEG_INF)
                  acc = log_sum(acc, sum_scores(cur_col[p], end_tbl[p], 0));
            end
            r.kind = KIND_TOTAL; r.idx = 6'd0; r.score = acc;
            pending_fwd.push_back(r);
         end
         default: ;  // undefined codes: drop
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Result checker: the receiver cannot stall, so take every strobe
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      fwd_result_type e;
      if (!reset && rsp_strobe) begin
         if (pending_fwd.size() == 0) begin
            $display("%0t: unexpected result kind=%0d idx=%0d score=%0d", $time,
                     rsp_result_kind, rsp_state_index, rsp_log_score);
            mismatch_count++;
         end else begin
            e = pending_fwd.pop_front();
            if (rsp_result_kind !== e.kind) begin
               $display("%0t: result_kind expected %0d actual %0d", $time,
                        e.kind, rsp_result_kind);
               mismatch_count++;
            end
            if (rsp_state_index !== e.idx) begin
               $display("%0t: state_index expected %0d actual %0d", $time,
                        e.idx, rsp_state_index);
               mismatch_count++;
            end
            if (rsp_log_score !== e.score) begin
               $display("%0t: log_score expected %0d actual %0d", $time,
                        e.score, rsp_log_score);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // scores mostly within +-16.0 so log-adds interact; extremes now and then
   function automatic logic signed [31:0] pick_score();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $signed($urandom_range(0, 32 << 16)) - (16 << 16);
      if (r < 78) return NEG_INF;
      if (r < 82) return POS_MAX;
      if (r < 86) return NEG_INF + $urandom_range(1, 3);
      if (r < 90) return POS_MAX - $urandom_range(0, 65536);
      return $urandom;
   endfunction

   // Hold the request until start and not busy meet at a rising edge.
   task automatic send_request(input logic [2:0] kind, input logic [5:0] src,
                               input logic [5:0] dst, input logic signed [31:0] sc,
                               input logic [1:0] mark);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start             = 1'b1;
      req_type          = kind;
      req_from_state    = src;
      req_to_state      = dst;
      req_score         = sc;
      req_position_mark = mark;
      do @(posedge clock); while (busy);
      predict_transfer(kind, src, dst, sc, mark);
   endtask

   // Drop start, wait for every expected result, then let the block settle.
   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (pending_fwd.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_states(input logic [6:0] val);
      wait_idle();
      csr_valid         = 1'b1;
      csr_states_in_use = val;
      do @(posedge clock); while (!csr_ready);
      states_cfg = val;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // One sequence: first state, several positions, then a finish.
   task automatic run_sequence(input int positions, input int per_pos);
      int         n;
      logic [5:0] dst;
      logic [1:0] mark;
      n = active_states();
      for (int p = 0; p < positions; p++) begin
         for (int j = 0; j < per_pos; j++) begin
            mark = (j != 0) ? MARK_SAME : (p == 0) ? MARK_FIRST : MARK_NEXT;
            if (n > 0 && $urandom_range(0, 9) != 0)
               dst = 6'($urandom_range(0, n - 1));
            else
               dst = 6'($urandom_range(0, 63));
            send_request(REQ_EMIT, 6'($urandom), dst, pick_score(), mark);
         end
      end
      send_request(REQ_FINISH, 6'($urandom), 6'($urandom), $urandom, 2'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // write every table entry so no later read hits an unwritten one
   task automatic test_load_tables();
      for (int s = 0; s < MAX_STATES_DEF; s++) begin
         send_request(REQ_SET_INIT, 6'($urandom), 6'(s), pick_score(), 2'($urandom));
         send_request(REQ_SET_END, 6'(s), 6'($urandom), pick_score(), 2'($urandom));
      end
      for (int f = 0; f < MAX_STATES_DEF; f++)
         for (int t = 0; t < MAX_STATES_DEF; t++)
            send_request(REQ_SET_TRANS, 6'(f), 6'(t), pick_score(), 2'($urandom));
   endtask

   task automatic test_directed();
      // score extremes through initial and transition entries, a zero end entry
      send_request(REQ_SET_INIT, 6'd0, 6'd0, POS_MAX, MARK_SAME);
      send_request(REQ_SET_INIT, 6'd0, 6'd63, NEG_INF, MARK_SAME);
      send_request(REQ_SET_TRANS, 6'd63, 6'd63, NEG_INF, MARK_SAME);
      send_request(REQ_SET_TRANS, 6'd0, 6'd1, POS_MAX, MARK_SAME);
      send_request(REQ_SET_END, 6'd63, 6'd0, 32'sd0, MARK_SAME);
      // first position: saturate high, minus infinity, plain
      send_request(REQ_EMIT, 6'd0, 6'd0, POS_MAX, MARK_FIRST);
      send_request(REQ_EMIT, 6'd0, 6'd63, 32'sd65536, MARK_SAME);
      send_request(REQ_EMIT, 6'd0, 6'd1, NEG_INF + 1, MARK_SPARE);
      // next position: log-add loop, then a same-position item
      send_request(REQ_EMIT, 6'd0, 6'd1, 32'sd0, MARK_NEXT);
      send_request(REQ_EMIT, 6'd0, 6'd63, NEG_INF, MARK_SAME);
      send_request(REQ_FINISH, 6'd0, 6'd0, 32'sd0, MARK_SAME);
      // undefined codes leave no trace
      for (int k = 0; k < 3; k++)
         send_request(REQ_SPARE_LO + 3'(k), 6'd63, 6'd63, NEG_INF, MARK_SPARE);
      send_request(REQ_FINISH, 6'd0, 6'd0, 32'sd0, MARK_SAME);
      // nonparticipating emitting state
      write_states(7'd4);
      send_request(REQ_EMIT, 6'd0, 6'd2, 32'sd0, MARK_FIRST);
      send_request(REQ_EMIT, 6'd0, 6'd40, 32'sd0, MARK_SAME);
      send_request(REQ_EMIT, 6'd0, 6'd3, -32'sd65536, MARK_NEXT);
      send_request(REQ_FINISH, 6'd0, 6'd0, 32'sd0, MARK_SAME);
      // zero states: every result is minus infinity
      write_states(7'd0);
      send_request(REQ_EMIT, 6'd0, 6'd0, 32'sd0, MARK_FIRST);
      send_request(REQ_FINISH, 6'd0, 6'd0, 32'sd0, MARK_SAME);
      // above the maximum acts as the maximum
      write_states(7'd127);
      run_sequence(2, 2);
   endtask

   task automatic test_random();
      int         sent;
      int         r;
      int         npos;
      int         nper;
      logic [6:0] sizes[6];
      sizes = '{7'd1, 7'd2, 7'd64, 7'd127, 7'd3, 7'd8};
      sent  = 0;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 5) write_states(7'($urandom_range(1, 16)));
         else write_states(sizes[phase]);
         gaps_on = (phase != 2);  // one stretch with back-to-back requests
         while (sent < (phase + 1) * RANDOM_ITEMS / 6) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               npos = $urandom_range(1, 5);
               nper = $urandom_range(1, 4);
               run_sequence(npos, nper);
               sent += npos * nper + 1;
            end else if (r < 95) begin
               // noise: retune a table entry, or a stray emission or finish with a random mark
               send_request(3'($urandom_range(0, 4)), 6'($urandom), 6'($urandom),
                            pick_score(), 2'($urandom));
               sent++;
            end else if (r < 98) begin
               send_request(3'($urandom_range(REQ_SPARE_LO, 7)), 6'($urandom),
                            6'($urandom), $urandom, 2'($urandom));
               sent++;
            end else begin
               // hold off until the block has answered everything
               wait_idle();
            end
         end
      end
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      mismatch_count    = 0;
      gaps_on           = 1'b1;
      reset             = 1'b1;
      start             = 1'b0;
      req_type          = REQ_SET_TRANS;
      req_from_state    = '0;
      req_to_state      = '0;
      req_score         = '0;
      req_position_mark = MARK_SAME;
      csr_valid         = 1'b0;
      csr_states_in_use = STATES_RESET;
      states_cfg        = STATES_RESET;
      first_pos         = 1'b1;
      foreach (prev_col[i]) begin
         prev_col[i] = NEG_INF;
         cur_col[i]  = NEG_INF;
         init_tbl[i] = '0;
         end_tbl[i]  = '0;
      end
      foreach (trans_tbl[i]) trans_tbl[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_load_tables();
      test_directed();
      test_random();

      wait_idle();
      if (pending_fwd.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog well past the slowest legal run
   initial begin
      #100000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
